// ----- src/i2cm_pkg.sv -----
// Shared types, codes and constants of the I2C master transaction engine.
`default_nettype none
package i2cm_pkg;

    // Transmit buffer depth and the widths that follow from it
    localparam int TX_DEPTH = 16;
    localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int TX_FW    = $clog2(TX_DEPTH + 1);
    localparam int TX_CW    = ((TX_FW > 5) ? TX_FW : 5) + 1;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_PUSH  = 2'd1;
    localparam logic [1:0] REQ_BEGIN = 2'd2;

    // Completion status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NACK   = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ADDRESS   = 2'd0;
    localparam logic [1:0] CFG_PHASE_TICKS      = 2'd1;
    localparam logic [1:0] CFG_WRITE_WAIT_TICKS = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  DEVICE_ADDRESS_RESET   = 8'hA0;
    localparam logic [15:0] PHASE_TICKS_RESET      = 16'd50;
    localparam logic [23:0] WRITE_WAIT_TICKS_RESET = 24'd2000;

    // Mask that clears the read/write bit of the address byte
    localparam logic [7:0] ADDR_RW_MASK = 8'hFE;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_START  = 9'b000000010,
        ST_ADDR_W = 9'b000000100,
        ST_DATA_W = 9'b000001000,
        ST_RSTART = 9'b000010000,
        ST_ADDR_R = 9'b000100000,
        ST_RDATA  = 9'b001000000,
        ST_STOP   = 9'b010000000,
        ST_WAIT   = 9'b100000000
    } phase_state_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] rx_data;
        logic       rx_valid;
        logic       rx_last;
        logic       done_res;
        logic [1:0] status;
        logic       busy_res;
    } res_t;

endpackage
`default_nettype wire

// ----- src/i2cm_if.sv -----
// Request and result channel interfaces of the I2C master transaction engine.
`default_nettype none
interface i2cm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic        sda_in;
    logic [7:0]  tx_byte;
    logic [4:0]  tx_count;
    logic [15:0] rx_count;
    logic        read_mode;

    modport source (
        output valid, req_type, sda_in, tx_byte, tx_count, rx_count, read_mode,
        input  ready
    );
    modport sink (
        input  valid, req_type, sda_in, tx_byte, tx_count, rx_count, read_mode,
        output ready
    );
endinterface

interface i2cm_res_if;
    logic        valid;
    logic        ready;
    logic        scl_out;
    logic        sda_out;
    logic [7:0]  rx_data;
    logic        rx_valid;
    logic        rx_last;
    logic        done_res;
    logic [1:0]  status;
    logic        busy_res;

    modport source (
        output valid, scl_out, sda_out, rx_data, rx_valid, rx_last, done_res, status,
               busy_res,
        input  ready
    );
    modport sink (
        input  valid, scl_out, sda_out, rx_data, rx_valid, rx_last, done_res, status,
               busy_res,
        output ready
    );
endinterface
`default_nettype wire

// ----- src/i2cm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module i2cm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- src/i2c_master_transaction_engine.sv -----
// Top level of the I2C master transaction engine.
// Every request item is handled as soon as it is accepted, so the engine takes one item per
// cycle; each item yields exactly one result item. A two-entry output stage (output
// register plus skid register) lets a new item in while a result waits, and request
// ready drops only when both entries are full. Tick items advance the SCL/SDA
// sequencer by one bus tick; push items write the transmit buffer RAM (16 x 8,
// one write and one registered read port), which is read ahead at the current read
// position so the next byte is ready long before the acknowledge slot uses it.
// Push and begin are ignored while a transaction runs. No clearing pass after reset.
`default_nettype none
module i2c_master_transaction_engine
    import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    i2cm_req_if.sink         req,
    i2cm_res_if.source       res,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    // Configuration
    logic [7:0]  dev_addr_reg;
    logic [15:0] phase_ticks_reg;
    logic [23:0] wait_ticks_reg;

    // Sequencer state
    phase_state_t   state_reg, state_next;
    logic [1:0]     quarter_reg, quarter_next;
    logic [23:0]    tick_reg, tick_next;
    logic [3:0]     bit_reg, bit_next;
    logic [7:0]     shift_reg, shift_next;
    logic [4:0]     left_tx_reg, left_tx_next;
    logic [15:0]    left_rx_reg, left_rx_next;
    logic           read_flag_reg, read_flag_next;
    logic           scl_reg, scl_next;
    logic           sda_reg, sda_next;
    logic           nack_reg, nack_next;
    logic [TX_FW-1:0] fill_reg, fill_next;
    logic [TX_FW-1:0] rpos_reg, rpos_next;

    // Output stage
    res_t out_reg, out_next;
    res_t skid_reg, skid_next;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t res_new;

    // Buffer RAM
    logic       ram_we;
    logic [7:0] ram_rdata;

    logic in_fire;
    logic out_fire;
    logic drv_scl;
    logic drv_sda;
    logic idle;

    assign in_fire  = req.valid & req.ready;
    assign out_fire = out_valid_reg & res.ready;
    assign req.ready = ~skid_valid_reg;
    assign idle = (state_reg == ST_IDLE);

    i2cm_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[TX_AW-1:0]),
        .wdata (req.tx_byte),
        .raddr (rpos_reg[TX_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Line levels for the current quarter
    always_comb
    begin
        drv_scl = (quarter_reg == 2'd1) || (quarter_reg == 2'd2);
        drv_sda = 1'b1;
        case (state_reg)
            ST_START, ST_RSTART:
            begin
                drv_scl = (quarter_reg == 2'd0) ? scl_reg : (quarter_reg != 2'd3);
                drv_sda = (quarter_reg < 2'd2);
            end
            ST_STOP:
            begin
                drv_scl = (quarter_reg != 2'd0);
                drv_sda = (quarter_reg == 2'd3);
            end
            ST_WAIT:
            begin
                drv_scl = 1'b1;
                drv_sda = 1'b1;
            end
            ST_RDATA:
            begin
                drv_sda = (bit_reg < 4'd8) ? 1'b1 : (left_rx_reg == 16'd1);
            end
            default:
            begin
                drv_sda = (bit_reg < 4'd8) ? shift_reg[7] : 1'b1;
            end
        endcase
    end

    always_comb
    begin
        logic [24:0] tick_sum;
        logic [15:0] pt;
        logic        do_finish;
        logic [15:0] rx_dec;

        tick_sum  = {1'b0, tick_reg} + 25'd1;
        pt        = (phase_ticks_reg == 16'd0) ? 16'd1 : phase_ticks_reg;
        do_finish = 1'b0;
        rx_dec    = left_rx_reg;

        state_next     = state_reg;
        quarter_next   = quarter_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        left_tx_next   = left_tx_reg;
        left_rx_next   = left_rx_reg;
        read_flag_next = read_flag_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        nack_next      = nack_reg;
        fill_next      = fill_reg;
        rpos_next      = rpos_reg;
        ram_we         = 1'b0;
        res_new        = '0;

        if (in_fire)
        begin
            case (req.req_type)
                REQ_TICK:
                begin
                    if (idle)
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = drv_scl;
                        sda_next = drv_sda;
                        if (state_reg == ST_WAIT)
                        begin
                            if (tick_sum >= {1'b0, wait_ticks_reg})
                            begin
                                do_finish = 1'b1;
                            end
                            else
                            begin
                                tick_next = tick_sum[23:0];
                            end
                        end
                        else if (tick_sum < {9'd0, pt})
                        begin
                            tick_next = tick_sum[23:0];
                        end
                        else
                        begin
                            tick_next = '0;
                            // Sample SDA at the end of the third quarter
                            if (quarter_reg == 2'd2)
                            begin
                                if (state_reg inside {ST_ADDR_W, ST_DATA_W, ST_ADDR_R})
                                begin
                                    if (bit_reg == 4'd8)
                                    begin
                                        nack_next = req.sda_in;
                                    end
                                end
                                else if (state_reg == ST_RDATA && bit_reg < 4'd8)
                                begin
                                    shift_next = {shift_reg[6:0], req.sda_in};
                                end
                            end
                            if (quarter_reg != 2'd3)
                            begin
                                quarter_next = quarter_reg + 2'd1;
                            end
                            else
                            begin
                                quarter_next = 2'd0;
                                // End of slot: pick the next slot
                                case (state_reg)
                                    ST_START:
                                    begin
                                        shift_next = dev_addr_reg & ADDR_RW_MASK;
                                        state_next = ST_ADDR_W;
                                        bit_next   = '0;
                                    end
                                    ST_RSTART:
                                    begin
                                        shift_next = (dev_addr_reg & ADDR_RW_MASK) | 8'd1;
                                        state_next = ST_ADDR_R;
                                        bit_next   = '0;
                                    end
                                    ST_ADDR_W, ST_DATA_W, ST_ADDR_R:
                                    begin
                                        if (bit_reg < 4'd8)
                                        begin
                                            shift_next = {shift_reg[6:0], 1'b0};
                                            bit_next   = bit_reg + 4'd1;
                                        end
                                        else
                                        begin
                                            bit_next = '0;
                                            if (nack_reg)
                                            begin
                                                state_next = ST_STOP;
                                            end
                                            else if (state_reg == ST_ADDR_R)
                                            begin
                                                if (left_rx_reg == 16'd0)
                                                begin
                                                    state_next = ST_STOP;
                                                end
                                                else
                                                begin
                                                    shift_next = '0;
                                                    state_next = ST_RDATA;
                                                end
                                            end
                                            else if (left_tx_reg != 5'd0 &&
                                                     rpos_reg < fill_reg &&
                                                     rpos_reg < TX_FW'(TX_DEPTH))
                                            begin
                                                // Byte at the read position is already out of the RAM
                                                shift_next   = ram_rdata;
                                                rpos_next    = rpos_reg + TX_FW'(1);
                                                left_tx_next = left_tx_reg - 5'd1;
                                                state_next   = ST_DATA_W;
                                            end
                                            else if (read_flag_reg)
                                            begin
                                                state_next = ST_RSTART;
                                            end
                                            else
                                            begin
                                                state_next = ST_STOP;
                                            end
                                        end
                                    end
                                    ST_RDATA:
                                    begin
                                        if (bit_reg < 4'd8)
                                        begin
                                            if (bit_reg == 4'd7)
                                            begin
                                                res_new.rx_valid = 1'b1;
                                                res_new.rx_data  = shift_reg;
                                                res_new.rx_last  = (left_rx_reg == 16'd1);
                                            end
                                            bit_next = bit_reg + 4'd1;
                                        end
                                        else
                                        begin
                                            if (left_rx_reg != 16'd0)
                                            begin
                                                rx_dec = left_rx_reg - 16'd1;
                                            end
                                            left_rx_next = rx_dec;
                                            bit_next     = '0;
                                            if (rx_dec == 16'd0)
                                            begin
                                                state_next = ST_STOP;
                                            end
                                            else
                                            begin
                                                shift_next = '0;
                                                state_next = ST_RDATA;
                                            end
                                        end
                                    end
                                    ST_STOP:
                                    begin
                                        if (!nack_reg && !read_flag_reg &&
                                            wait_ticks_reg != 24'd0)
                                        begin
                                            state_next = ST_WAIT;
                                            bit_next   = '0;
                                            tick_next  = '0;
                                        end
                                        else
                                        begin
                                            do_finish = 1'b1;
                                        end
                                    end
                                    default:
                                    begin
                                        state_next = state_reg;
                                    end
                                endcase
                            end
                        end
                    end
                end
                REQ_PUSH:
                begin
                    if (idle && fill_reg < TX_FW'(TX_DEPTH))
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + TX_FW'(1);
                    end
                end
                REQ_BEGIN:
                begin
                    if (idle)
                    begin
                        if ({{(TX_CW-5){1'b0}}, req.tx_count} >
                            {{(TX_CW-TX_FW){1'b0}}, fill_reg})
                        begin
                            res_new.done_res = 1'b1;
                            res_new.status   = STATUS_REJECT;
                        end
                        else
                        begin
                            left_tx_next   = req.tx_count;
                            left_rx_next   = req.rx_count;
                            read_flag_next = req.read_mode;
                            rpos_next      = '0;
                            nack_next      = 1'b0;
                            shift_next     = '0;
                            quarter_next   = '0;
                            tick_next      = '0;
                            state_next     = ST_START;
                            bit_next       = '0;
                        end
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase

            if (do_finish)
            begin
                state_next       = ST_IDLE;
                quarter_next     = '0;
                tick_next        = '0;
                bit_next         = '0;
                fill_next        = '0;
                rpos_next        = '0;
                res_new.done_res = 1'b1;
                res_new.status   = nack_reg ? STATUS_NACK : STATUS_OK;
            end
        end

        res_new.scl_out  = scl_next;
        res_new.sda_out  = sda_next;
        res_new.busy_res = (state_next != ST_IDLE);
    end

    // Output register and skid register
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && !out_fire)
        begin
            // Hold the waiting result; park a new one in the skid register
            if (in_fire)
            begin
                skid_next       = res_new;
                skid_valid_next = 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_next        = skid_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_next       = res_new;
            out_valid_next = in_fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg    <= DEVICE_ADDRESS_RESET;
            phase_ticks_reg <= PHASE_TICKS_RESET;
            wait_ticks_reg  <= WRITE_WAIT_TICKS_RESET;
            state_reg       <= ST_IDLE;
            quarter_reg     <= '0;
            tick_reg        <= '0;
            bit_reg         <= '0;
            shift_reg       <= '0;
            left_tx_reg     <= '0;
            left_rx_reg     <= '0;
            read_flag_reg   <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            nack_reg        <= 1'b0;
            fill_reg        <= '0;
            rpos_reg        <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEVICE_ADDRESS:   dev_addr_reg    <= cfg_data[7:0];
                    CFG_PHASE_TICKS:      phase_ticks_reg <= cfg_data[15:0];
                    CFG_WRITE_WAIT_TICKS: wait_ticks_reg  <= cfg_data;
                    default:              dev_addr_reg    <= dev_addr_reg;
                endcase
            end
            state_reg      <= state_next;
            quarter_reg    <= quarter_next;
            tick_reg       <= tick_next;
            bit_reg        <= bit_next;
            shift_reg      <= shift_next;
            left_tx_reg    <= left_tx_next;
            left_rx_reg    <= left_rx_next;
            read_flag_reg  <= read_flag_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            nack_reg       <= nack_next;
            fill_reg       <= fill_next;
            rpos_reg       <= rpos_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign res.valid    = out_valid_reg;
    assign res.scl_out  = out_reg.scl_out;
    assign res.sda_out  = out_reg.sda_out;
    assign res.rx_data  = out_reg.rx_data;
    assign res.rx_valid = out_reg.rx_valid;
    assign res.rx_last  = out_reg.rx_last;
    assign res.done_res = out_reg.done_res;
    assign res.status   = out_reg.status;
    assign res.busy_res = out_reg.busy_res;

endmodule
`default_nettype wire
